@@ hdl/dpst_pkg.sv @@
// package for the degree-phase sine tone generator
// widths, register indexes, quarter-wave table and the queue slot type; no dependencies
`timescale 1ns / 1ps

package dpst_pkg;

    localparam int PHASE_FRACTION_BITS = 16;
    localparam int DEG_W   = 9;
    localparam int ACC_W   = DEG_W + PHASE_FRACTION_BITS;
    localparam int STEP_W  = 25;
    localparam int VOL_W   = 3;
    localparam int SUM_W   = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
    localparam int IDX_W   = 7;
    localparam int TAB_N   = 1 << IDX_W;
    localparam int MAG_W   = 31;
    localparam int SMP_W   = 32;
    localparam int CFG_W   = 25;
    localparam int CFG_IDX_W = 2;
    localparam int AMP_SHIFT = 23;
    localparam int VOL_MAX = (1 << VOL_W) - 1;
    localparam longint TABLE_SCALE = 100000;

    localparam logic [SUM_W-1:0] FULL_TURN = SUM_W'(64'd360 << PHASE_FRACTION_BITS);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(491520);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_ENABLE = 2'd2;

    // sin(deg) * 100000 for 0..90 degrees
    localparam logic [16:0] QUARTER_SINE [0:90] = '{
        17'd0, 17'd1745, 17'd3490, 17'd5234, 17'd6976, 17'd8716, 17'd10453, 17'd12187,
        17'd13917, 17'd15643, 17'd17365, 17'd19081, 17'd20791, 17'd22495, 17'd24192,
        17'd25882, 17'd27564, 17'd29237, 17'd30902, 17'd32557, 17'd34202, 17'd35837,
        17'd37461, 17'd39073, 17'd40674, 17'd42262, 17'd43837, 17'd45399, 17'd46947,
        17'd48481, 17'd50000, 17'd51504, 17'd52992, 17'd54464, 17'd55919, 17'd57358,
        17'd58779, 17'd60182, 17'd61566, 17'd62932, 17'd64279, 17'd65606, 17'd66913,
        17'd68200, 17'd69466, 17'd70711, 17'd71934, 17'd73135, 17'd74314, 17'd75471,
        17'd76604, 17'd77715, 17'd78801, 17'd79864, 17'd80902, 17'd81915, 17'd82904,
        17'd83867, 17'd84805, 17'd85717, 17'd86603, 17'd87462, 17'd88295, 17'd89101,
        17'd89879, 17'd90631, 17'd91355, 17'd92050, 17'd92718, 17'd93358, 17'd93969,
        17'd94552, 17'd95106, 17'd95630, 17'd96126, 17'd96593, 17'd97030, 17'd97437,
        17'd97815, 17'd98163, 17'd98481, 17'd98769, 17'd99027, 17'd99255, 17'd99452,
        17'd99619, 17'd99756, 17'd99863, 17'd99939, 17'd99985, 17'd100000
    };

    typedef logic [MAG_W-1:0] t_scaled_tab [0:TAB_N-1];

    // floor(entry * 2^(23+7) / 100000); smaller gains are exact right shifts of this
    function automatic t_scaled_tab f_scaled_tab();
        t_scaled_tab tab;
        for (int i = 0; i < TAB_N; i++) begin
            if (i <= 90) begin
                tab[i] = MAG_W'((64'(QUARTER_SINE[i]) << (AMP_SHIFT + VOL_MAX))
                                / TABLE_SCALE);
            end else begin
                tab[i] = '0;
            end
        end
        return tab;
    endfunction

    localparam t_scaled_tab SCALED_SINE = f_scaled_tab();

    // one folded sample slot waiting for the back end
    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] idx;
    } t_slot;

endpackage

@@ hdl/dpst_in_if.sv @@
// input channel of the tone generator: one sample slot request per item
// depends on nothing
`timescale 1ns / 1ps

interface dpst_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

@@ hdl/dpst_out_if.sv @@
// output channel of the tone generator: one signed sample per item
// depends on nothing
`timescale 1ns / 1ps

interface dpst_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ hdl/dpst_front.sv @@
// front end: phase accumulator, restart and enable handling, quadrant fold
// depends on dpst_pkg
`timescale 1ns / 1ps

module dpst_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_restart,
    input  logic [dpst_pkg::STEP_W-1:0] i_step,
    input  logic                       i_enable,
    input  logic                       i_full,
    output logic                       o_push,
    output dpst_pkg::t_slot            o_slot
);
    import dpst_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] base;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    logic [ACC_W-1:0] phase;
    logic [DEG_W-1:0] deg;
    logic [DEG_W-1:0] fold;
    logic             accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_enable;

    always_comb begin
        base    = i_restart ? '0 : r_acc;
        sum     = SUM_W'(base) + SUM_W'(i_step);
        wrapped = (sum >= FULL_TURN) ? (sum - FULL_TURN) : sum;
        phase   = ACC_W'(wrapped);
        deg     = phase[ACC_W-1 -: DEG_W];

        n_acc = r_acc;
        if (o_push) begin
            n_acc = phase;
        end else if (accept && i_restart) begin
            n_acc = '0;
        end
    end

    // fold onto the quarter wave; past a full turn the table answer is zero
    always_comb begin
        o_slot.neg = 1'b0;
        fold       = '0;
        if (deg <= DEG_W'(90)) begin
            fold = deg;
        end else if (deg <= DEG_W'(180)) begin
            fold = DEG_W'(180) - deg;
        end else if (deg <= DEG_W'(270)) begin
            o_slot.neg = 1'b1;
            fold       = deg - DEG_W'(180);
        end else if (deg <= DEG_W'(360)) begin
            o_slot.neg = 1'b1;
            fold       = DEG_W'(360) - deg;
        end
        o_slot.idx = fold[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

@@ hdl/dpst_queue.sv @@
// short slot queue between front and back end
// depends on dpst_pkg
`timescale 1ns / 1ps

module dpst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dpst_pkg::t_slot i_slot,
    input  logic            i_pop,
    output dpst_pkg::t_slot o_slot,
    output logic            o_full,
    output logic            o_empty
);
    import dpst_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_slot            r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_slot  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/dpst_back.sv @@
// back end: table lookup, gain shift, sign and the output register
// depends on dpst_pkg
`timescale 1ns / 1ps

module dpst_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_avail,
    input  dpst_pkg::t_slot             i_slot,
    input  logic [dpst_pkg::VOL_W-1:0]  i_volume,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dpst_pkg::SMP_W-1:0]  o_sample
);
    import dpst_pkg::*;

    logic             r_valid;
    logic [SMP_W-1:0] r_sample;
    logic [VOL_W-1:0] shamt;
    logic [MAG_W-1:0] mag;
    logic [SMP_W-1:0] mag_ext;
    logic [SMP_W-1:0] n_sample;

    assign o_pop    = i_avail && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_sample = r_sample;

    // table holds full gain; lower gains drop bits, which stays exact floor
    always_comb begin
        shamt    = VOL_W'(VOL_MAX) - i_volume;
        mag      = SCALED_SINE[i_slot.idx] >> shamt;
        mag_ext  = SMP_W'(mag);
        n_sample = i_slot.neg ? (SMP_W'(0) - mag_ext) : mag_ext;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= n_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

@@ hdl/degree_phase_sine_tone_generator.sv @@
// top level of the degree-phase sine tone generator
// depends on dpst_pkg, dpst_in_if, dpst_out_if, dpst_front, dpst_queue, dpst_back
`timescale 1ns / 1ps

// Usage:
//   i_slot carries one item per audio sample slot, with a restart flag that
//   clears the phase before that slot is worked. o_smp returns one signed
//   sample per slot, the same value serving left and right.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data: index 0 is
//   the phase step (degrees, 16 fraction bits), 1 the volume shift, 2 the
//   sound enable. Write only while no item is in flight.
//   With sound disabled an accepted item gives no sample and leaves the phase
//   alone, though restart still clears it.
//   From acceptance an item goes through the queue slot that the front end
//   writes and then through the output register to o_smp.valid. Throughput is
//   one item per cycle while the queue has room; the phase add and wrap loop on r_acc.
//   A four-slot queue sits between front and back end, so input keeps being
//   taken while the receiver stalls until that queue fills, and then
//   i_slot.ready drops. Synchronous reset clears the phase, the queue and the
//   output valid, and loads step 491520, volume 0 and sound enabled.

module degree_phase_sine_tone_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dpst_in_if.sink                        i_slot,
    dpst_out_if.source                     o_smp,
    input  logic                           i_cfg_we,
    input  logic [dpst_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dpst_pkg::CFG_W-1:0]     i_cfg_data
);
    import dpst_pkg::*;

    logic [STEP_W-1:0] r_phase_step;
    logic [VOL_W-1:0]  r_volume;
    logic              r_enable;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_slot front_slot;
    t_slot head_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= STEP_RESET;
            r_volume     <= '0;
            r_enable     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PHASE_STEP:   r_phase_step <= i_cfg_data[STEP_W-1:0];
                REG_VOLUME_SHIFT: r_volume     <= i_cfg_data[VOL_W-1:0];
                REG_SOUND_ENABLE: r_enable     <= i_cfg_data[0];
                default:          r_enable     <= r_enable;
            endcase
        end
    end

    dpst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_slot.valid),
        .o_ready   (i_slot.ready),
        .i_restart (i_slot.restart),
        .i_step    (r_phase_step),
        .i_enable  (r_enable),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_slot    (front_slot)
    );

    dpst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_slot  (front_slot),
        .i_pop   (q_pop),
        .o_slot  (head_slot),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dpst_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!q_empty),
        .i_slot   (head_slot),
        .i_volume (r_volume),
        .o_pop    (q_pop),
        .o_valid  (o_smp.valid),
        .i_ready  (o_smp.ready),
        .o_sample (o_smp.sample)
    );

endmodule
